[hdl/u2a_pkg.sv]
// Shared types, character codes and folding functions for the UTF-8 to ASCII folder.
`timescale 1ns / 1ps
`default_nettype none
package u2a_pkg;

  // Folded characters that one input beat can cause, oldest first in slot 0.
  typedef struct packed {
    logic [2:0][6:0] chars;
    logic [1:0]      cnt;
  } run_t;

  localparam logic [6:0] CH_LF     = 7'h0A;
  localparam logic [6:0] CH_SPACE  = 7'h20;
  localparam logic [6:0] CH_QMARK  = 7'h3F;
  localparam logic [6:0] CH_APOS   = 7'h27;
  localparam logic [6:0] CH_DQUOTE = 7'h22;
  localparam logic [6:0] CH_DASH   = 7'h2D;
  localparam logic [6:0] CH_DOT    = 7'h2E;
  localparam logic [6:0] CH_UA     = 7'h41;
  localparam logic [6:0] CH_UE     = 7'h45;
  localparam logic [6:0] CH_LA     = 7'h61;
  localparam logic [6:0] CH_LE     = 7'h65;
  localparam logic [6:0] CH_LS     = 7'h73;

  localparam logic [1:0] MAX_CHARS = 2'd3;

  // Base letters for code points C0..FF, first character in the top byte.
  localparam logic [8*64-1:0] LATIN1_BASE =
    "AAAAAAACEEEEIIIIDNOOOOOxOUUUUYTsaaaaaaaceeeeiiiidnooooo/ouuuuyty";

  localparam logic [20:0] CP_MAX = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;

  // Append one character; a full run drops it.
  function automatic run_t add_char(run_t r, logic [6:0] c);
    run_t o;
    o = r;
    if (r.cnt < MAX_CHARS) begin
      o.chars[r.cnt] = c;
      o.cnt = r.cnt + 2'd1;
    end
    return o;
  endfunction

  // Append all characters of run b to run a.
  function automatic run_t add_run(run_t a, run_t b);
    run_t o;
    o = a;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < b.cnt) o = add_char(o, b.chars[i]);
    end
    return o;
  endfunction

  function automatic logic [6:0] latin1_letter(logic [5:0] idx);
    logic [8:0] pos;
    pos = {~idx, 3'b000};
    return LATIN1_BASE[pos +: 7];
  endfunction

  // Fold one code point into zero to three ASCII characters.
  function automatic run_t fold_cp(logic [20:0] cp);
    run_t r;
    r = '0;
    if (cp == 21'h0A || cp == 21'h0D) begin
      r = add_char(r, CH_LF);
    end else if (cp == 21'h09) begin
      r = add_char(r, CH_SPACE);
    end else if (cp < 21'h20) begin
      r = '0;
    end else if (cp < 21'h7F) begin
      r = add_char(r, cp[6:0]);
    end else if (cp == 21'h00A0) begin
      r = add_char(r, CH_SPACE);
    end else if (cp == 21'h00C6) begin
      r = add_char(add_char(r, CH_UA), CH_UE);
    end else if (cp == 21'h00E6) begin
      r = add_char(add_char(r, CH_LA), CH_LE);
    end else if (cp == 21'h00DF) begin
      r = add_char(add_char(r, CH_LS), CH_LS);
    end else if (cp >= 21'h00C0 && cp <= 21'h00FF) begin
      r = add_char(r, latin1_letter(cp[5:0]));
    end else if (cp == 21'h2018 || cp == 21'h2019 || cp == 21'h201A) begin
      r = add_char(r, CH_APOS);
    end else if (cp == 21'h201C || cp == 21'h201D || cp == 21'h201E) begin
      r = add_char(r, CH_DQUOTE);
    end else if (cp == 21'h2013 || cp == 21'h2014 || cp == 21'h2212 ||
                 cp == 21'h2022 || cp == 21'h00B7) begin
      r = add_char(r, CH_DASH);
    end else if (cp == 21'h2026) begin
      r = add_char(add_char(add_char(r, CH_DOT), CH_DOT), CH_DOT);
    end else begin
      r = add_char(r, CH_QMARK);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/u2a_if.sv]
// Valid/ready channel interfaces for raw input bytes and folded output characters.
`timescale 1ns / 1ps
`default_nettype none
interface u2a_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;
  modport source(output valid, in_byte, end_of_text, input ready);
  modport sink(input valid, in_byte, end_of_text, output ready);
endinterface

interface u2a_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic       last_of_run;
  modport source(output valid, ascii_char, last_of_run, input ready);
  modport sink(input valid, ascii_char, last_of_run, output ready);
endinterface
`default_nettype wire

[hdl/u2a_front.sv]
// Front end: accepts bytes, runs the UTF-8 decode state and folds to a run of characters.
`timescale 1ns / 1ps
`default_nettype none
module u2a_front (
  input  wire logic        clk,
  input  wire logic        rst,
  u2a_in_if.sink           bytes,
  input  wire logic        queue_full,
  output logic             push,
  output u2a_pkg::run_t    run
);
  import u2a_pkg::*;

  logic [20:0] partial_code;
  logic [1:0]  bytes_remaining;
  logic [20:0] partial_code_next;
  logic [1:0]  bytes_remaining_next;
  logic [20:0] cont_code;
  logic [1:0]  cont_left;
  logic        do_lead;
  logic        accept;
  logic [7:0]  b;

  assign bytes.ready = !queue_full;
  assign accept = bytes.valid && bytes.ready;
  assign b = bytes.in_byte;
  assign cont_code = {partial_code[14:0], b[5:0]};
  assign cont_left = bytes_remaining - 2'd1;

  // Decode one byte into its run and the next sequence state.
  always_comb begin
    run = '0;
    partial_code_next = partial_code;
    bytes_remaining_next = bytes_remaining;
    do_lead = 1'b0;
    if (bytes_remaining == 2'd0) begin
      do_lead = 1'b1;
    end else if (b[7:6] == 2'b10) begin
      partial_code_next = cont_code;
      bytes_remaining_next = cont_left;
      if (cont_left == 2'd0) begin
        partial_code_next = '0;
        if (cont_code > CP_MAX || (cont_code >= CP_SURR_LO && cont_code <= CP_SURR_HI)) begin
          run = add_char(run, CH_QMARK);
        end else begin
          run = fold_cp(cont_code);
        end
      end
    end else begin
      // A broken sequence reports once, then the byte starts over as a lead.
      partial_code_next = '0;
      bytes_remaining_next = 2'd0;
      run = add_char(run, CH_QMARK);
      do_lead = 1'b1;
    end

    if (do_lead) begin
      if (!b[7]) begin
        run = add_run(run, fold_cp({13'd0, b}));
      end else if (b[7:3] == 5'b11110) begin
        partial_code_next = {18'd0, b[2:0]};
        bytes_remaining_next = 2'd3;
      end else if (b >= 8'hE0) begin
        partial_code_next = {17'd0, b[3:0]};
        bytes_remaining_next = 2'd2;
      end else if (b >= 8'hC2) begin
        partial_code_next = {16'd0, b[4:0]};
        bytes_remaining_next = 2'd1;
      end else begin
        run = add_char(run, CH_QMARK);
      end
    end

    // Text ending inside a sequence reports the truncation.
    if (bytes.end_of_text && bytes_remaining_next != 2'd0) begin
      partial_code_next = '0;
      bytes_remaining_next = 2'd0;
      run = add_char(run, CH_QMARK);
    end
  end

  assign push = accept && (run.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code <= '0;
      bytes_remaining <= '0;
    end else if (accept) begin
      partial_code <= partial_code_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule
`default_nettype wire

[hdl/u2a_queue.sv]
// Small FIFO of character runs between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module u2a_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire u2a_pkg::run_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               nonempty,
  output u2a_pkg::run_t      pop_data
);
  import u2a_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign pop_data = mem[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule
`default_nettype wire

[hdl/u2a_back.sv]
// Back end: holds one run and sends its characters one beat at a time.
`timescale 1ns / 1ps
`default_nettype none
module u2a_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          queue_nonempty,
  input  wire u2a_pkg::run_t queue_data,
  output logic               pop,
  u2a_out_if.source          chars
);
  import u2a_pkg::*;

  run_t       cur;
  logic [1:0] idx;
  logic       busy;
  logic       is_last;
  logic       out_acc;

  assign is_last = (idx == cur.cnt - 2'd1);
  assign out_acc = chars.valid && chars.ready;
  assign chars.valid = busy;
  assign chars.ascii_char = cur.chars[idx];
  assign chars.last_of_run = is_last;

  // Load the next run as soon as the current one is done or the holder is empty.
  assign pop = queue_nonempty && (!busy || (out_acc && is_last));

  always_ff @(posedge clk) begin
    if (pop) cur <= queue_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (out_acc) begin
      if (is_last) begin
        busy <= 1'b0;
        idx <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/utf8_to_ascii_folder_core.sv]
// Top level of the UTF-8 to ASCII folder: front end, run queue and back end.
//
//   channel  dir  payload                       beat means
//   bytes    in   in_byte[7:0], end_of_text     one raw UTF-8 byte
//   chars    out  ascii_char[6:0], last_of_run  one folded ASCII character
//
// A byte is taken every cycle while the run queue has room; its decode and
// folding finish in the cycle it is taken. Each byte yields zero to three
// characters; the back end sends one character per ready cycle, so the output
// beat count bounds throughput. Bytes that yield nothing still take a beat.
// Reset is synchronous and clears the decode state, the queue and the back end.
// A stall on chars fills the queue of QUEUE_DEPTH runs before bytes stalls.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_ascii_folder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  u2a_in_if.sink    bytes,
  u2a_out_if.source chars
);
  import u2a_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic nonempty;
  run_t push_data;
  run_t pop_data;

  u2a_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .queue_full (full),
    .push       (push),
    .run        (push_data)
  );

  u2a_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .pop_data  (pop_data)
  );

  u2a_back u_back (
    .clk            (clk),
    .rst            (rst),
    .queue_nonempty (nonempty),
    .queue_data     (pop_data),
    .pop            (pop),
    .chars          (chars)
  );

endmodule
`default_nettype wire

[hdl/u2a_checker.sv]
// Port-level checks for the UTF-8 to ASCII folder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module u2a_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] ascii_char,
  input wire logic       last_of_run
);
  import u2a_pkg::*;

  // A stalled output beat keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ascii_char) && $stable(last_of_run))
    else $error("output beat changed while stalled");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Only multi-character folds and error marks can precede more characters of a run.
  a_non_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |->
      ascii_char == CH_UA || ascii_char == CH_LA || ascii_char == CH_LS ||
      ascii_char == CH_DOT || ascii_char == CH_QMARK)
    else $error("unexpected character before end of run");

  // Input backpressure only happens while output is pending.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no output pending");

endmodule

bind utf8_to_ascii_folder_core u2a_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (bytes.ready),
  .out_valid   (chars.valid),
  .out_ready   (chars.ready),
  .ascii_char  (chars.ascii_char),
  .last_of_run (chars.last_of_run)
);
`default_nettype wire

[tb/utf8_to_ascii_folder_core_tb.sv]
// Self-checking testbench for the UTF-8 to ASCII folder core: directed bytes, then random text.
`timescale 1ns / 1ps
module utf8_to_ascii_folder_core_tb;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_BYTES  = 184;
  localparam int MAX_REPORTS   = 10;
  localparam int MAX_RUN       = 3;
  // A row count of this value means the expected run comes from the decoder model.
  localparam int FROM_MODEL    = -1;

  localparam logic [6:0] NO_CHAR  = 7'h00;
  localparam logic [6:0] LF_CH    = 7'h0A;
  localparam logic [6:0] SPACE_CH = 7'h20;
  localparam logic [6:0] QMARK_CH = 7'h3F;
  localparam logic [6:0] APOS_CH  = 7'h27;
  localparam logic [6:0] QUOTE_CH = 7'h22;
  localparam logic [6:0] DASH_CH  = 7'h2D;
  localparam logic [6:0] DOT_CH   = 7'h2E;
  localparam logic [6:0] TILDE_CH = 7'h7E;
  localparam logic [6:0] UPPER_A  = 7'h41;
  localparam logic [6:0] UPPER_E  = 7'h45;
  localparam logic [6:0] LOWER_A  = 7'h61;
  localparam logic [6:0] LOWER_E  = 7'h65;
  localparam logic [6:0] LOWER_S  = 7'h73;

  localparam logic [20:0] CP_LIMIT   = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST = 21'h00D800;
  localparam logic [20:0] SURR_LAST  = 21'h00DFFF;

  // Base letters of U+00C0..U+00FF, the first one in the top byte.
  localparam logic [8*64-1:0] BASE_LETTERS =
    "AAAAAAACEEEEIIIIDNOOOOOxOUUUUYTsaaaaaaaceeeeiiiidnooooo/ouuuuyty";

  typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_QUARTER} rx_mode_t;

  typedef struct {
    logic [7:0] b;
    logic       eot;
    int         typed_cnt;
    logic [6:0] typed_ch;
  } text_beat_t;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } char_exp_t;

  logic clk;
  logic rst;

  u2a_in_if  bytes_if();
  u2a_out_if chars_if();

  utf8_to_ascii_folder_core uut (
    .clk  (clk),
    .rst  (rst),
    .bytes(bytes_if),
    .chars(chars_if)
  );

  // Decoder state of the model and the characters it still owes.
  logic [20:0] dec_code;
  logic [1:0]  dec_left;
  logic [6:0]  run_chars[$];
  char_exp_t   expected_chars[$];

  text_beat_t dir_rows[$];
  text_beat_t random_text[$];

  int  fail_count;
  int  burst_left;
  int  cycle_count;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $time, what);
  endfunction

  // A run holds at most three characters; extra ones are dropped.
  function automatic void put_char(input logic [6:0] c);
    if (run_chars.size() < MAX_RUN) run_chars.insert(run_chars.size(), c);
  endfunction

  // Fold one code point into the current run.
  function automatic void fold_code(input logic [20:0] cp);
    if (cp == 21'h0A || cp == 21'h0D) begin
      put_char(LF_CH);
    end else if (cp == 21'h09) begin
      put_char(SPACE_CH);
    end else if (cp < 21'h20) begin
      // Other C0 controls, NUL among them, produce nothing.
    end else if (cp < 21'h7F) begin
      put_char(cp[6:0]);
    end else begin
      case (cp)
        21'h00A0: put_char(SPACE_CH);
        21'h00C6: begin
          put_char(UPPER_A);
          put_char(UPPER_E);
        end
        21'h00E6: begin
          put_char(LOWER_A);
          put_char(LOWER_E);
        end
        21'h00DF: begin
          put_char(LOWER_S);
          put_char(LOWER_S);
        end
        21'h2018, 21'h2019, 21'h201A: put_char(APOS_CH);
        21'h201C, 21'h201D, 21'h201E: put_char(QUOTE_CH);
        21'h2013, 21'h2014, 21'h2212, 21'h2022, 21'h00B7: put_char(DASH_CH);
        21'h2026: begin
          put_char(DOT_CH);
          put_char(DOT_CH);
          put_char(DOT_CH);
        end
        default: begin
          if (cp >= 21'h00C0 && cp <= 21'h00FF)
            put_char(BASE_LETTERS[8 * (63 - int'(cp[5:0])) +: 7]);
          else
            put_char(QMARK_CH);
        end
      endcase
    end
  endfunction

  // Handle a byte that starts a new character.
  function automatic void decode_lead(input logic [7:0] b);
    if (b < 8'h80) begin
      fold_code({13'd0, b});
    end else if (b >= 8'hF0 && b <= 8'hF7) begin
      dec_code = {18'd0, b[2:0]};
      dec_left = 2'd3;
    end else if (b >= 8'hE0) begin
      // F8..FF are taken as three-byte leads as well.
      dec_code = {17'd0, b[3:0]};
      dec_left = 2'd2;
    end else if (b >= 8'hC2) begin
      dec_code = {16'd0, b[4:0]};
      dec_left = 2'd1;
    end else begin
      put_char(QMARK_CH);
    end
  endfunction

  // Advance the decoder by one byte and leave its characters in run_chars.
  function automatic void decode_step(input logic [7:0] b, input logic eot);
    logic [20:0] cp;
    run_chars.delete();
    if (dec_left == 2'd0) begin
      decode_lead(b);
    end else if (b[7:6] == 2'b10) begin
      dec_code = {dec_code[14:0], b[5:0]};
      dec_left = dec_left - 2'd1;
      if (dec_left == 2'd0) begin
        cp = dec_code;
        dec_code = '0;
        if (cp > CP_LIMIT || (cp >= SURR_FIRST && cp <= SURR_LAST))
          put_char(QMARK_CH);
        else
          fold_code(cp);
      end
    end else begin
      // Broken sequence: flag it, then restart on this byte.
      dec_code = '0;
      dec_left = 2'd0;
      put_char(QMARK_CH);
      decode_lead(b);
    end
    // Text ended in the middle of a sequence.
    if (eot && dec_left != 2'd0) begin
      dec_code = '0;
      dec_left = 2'd0;
      put_char(QMARK_CH);
    end
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic eot, input int cnt,
                                  input logic [6:0] ch);
    text_beat_t t;
    t.b = b;
    t.eot = eot;
    t.typed_cnt = cnt;
    t.typed_ch = ch;
    dir_rows.insert(dir_rows.size(), t);
  endfunction

  function automatic void push_text(input logic [7:0] b);
    text_beat_t t;
    t.b = b;
    t.eot = ($urandom_range(0, 11) == 0);
    t.typed_cnt = FROM_MODEL;
    t.typed_ch = NO_CHAR;
    random_text.insert(random_text.size(), t);
  endfunction

  // Encode a code point in n bytes; now and then the sequence is cut short.
  function automatic void push_code(input logic [20:0] cp, input int n);
    logic [7:0] seq[4];
    int keep;
    case (n)
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : n;
    for (int k = 0; k < keep; k++) push_text(seq[k]);
  endfunction

  // Mostly well-formed text with random content, plus some noise bytes.
  function automatic void gen_random_text();
    int pick;
    logic [20:0] cp;
    while (random_text.size() < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        push_text($urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7E))
                                       : 8'($urandom_range(0, 8'h7F)));
      end else if (pick < 65) begin
        cp = 21'($urandom_range(0, 1) ? $urandom_range(21'h80, 21'hFF)
                                      : $urandom_range(21'h100, 21'h7FF));
        push_code(cp, 2);
      end else if (pick < 82) begin
        case ($urandom_range(0, 3))
          0: begin
            case ($urandom_range(0, 10))
              0: cp = 21'h2018;
              1: cp = 21'h2019;
              2: cp = 21'h201A;
              3: cp = 21'h201C;
              4: cp = 21'h201D;
              5: cp = 21'h201E;
              6: cp = 21'h2013;
              7: cp = 21'h2014;
              8: cp = 21'h2212;
              9: cp = 21'h2022;
              default: cp = 21'h2026;
            endcase
          end
          1: cp = 21'($urandom_range(SURR_FIRST, SURR_LAST));
          default: cp = 21'($urandom_range(21'h0, 21'hFFFF));
        endcase
        push_code(cp, 3);
      end else if (pick < 90) begin
        cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
        push_code(cp, 4);
      end else begin
        push_text(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // Offer one byte in a bursty pattern and record what it should produce.
  task automatic send_beat(input text_beat_t t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        bytes_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    bytes_if.valid       <= 1'b1;
    bytes_if.in_byte     <= t.b;
    bytes_if.end_of_text <= t.eot;
    do @(posedge clk); while (!bytes_if.ready);
    decode_step(t.b, t.eot);
    if (t.typed_cnt != FROM_MODEL) begin
      run_chars.delete();
      if (t.typed_cnt == 1) run_chars.insert(run_chars.size(), t.typed_ch);
    end
    foreach (run_chars[i]) begin
      char_exp_t e;
      e.ch = run_chars[i];
      e.last = (i == run_chars.size() - 1);
      expected_chars.insert(expected_chars.size(), e);
    end
    @(negedge clk);
  endtask

  // Stop sending until every expected character has come out.
  task automatic wait_for_drain();
    bytes_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stall patterns, plus one long hold-off on request.
  initial begin : receiver
    rx_mode_t mode;
    int mode_left;
    int phase;
    chars_if.ready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        chars_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_OPEN:   chars_if.ready <= 1'b1;
          RX_COIN:   chars_if.ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: chars_if.ready <= ($urandom_range(0, 3) != 0);
          default:   chars_if.ready <= (phase % 4 == 0);
        endcase
      end
    end
  end

  // Compare each character beat with the oldest expectation.
  always @(posedge clk) begin : char_monitor
    char_exp_t want;
    if (!rst && chars_if.valid && chars_if.ready) begin
      if (expected_chars.size() == 0) begin
        note_failure($sformatf("unexpected beat: char %h last %b",
                               chars_if.ascii_char, chars_if.last_of_run));
      end else begin
        want = expected_chars.pop_front();
        if (chars_if.ascii_char !== want.ch || chars_if.last_of_run !== want.last)
          note_failure($sformatf("mismatch: expected char %h last %b, got char %h last %b",
                                 want.ch, want.last, chars_if.ascii_char,
                                 chars_if.last_of_run));
      end
    end
  end

  // Cycle limit for a hung run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence: reset, directed rows, random text, drain.
  initial begin : main_seq
    bytes_if.valid       = 1'b0;
    bytes_if.in_byte     = 8'h00;
    bytes_if.end_of_text = 1'b0;
    rst        = 1'b1;
    dec_code   = '0;
    dec_left   = 2'd0;
    fail_count = 0;
    burst_left = 0;
    hold_req   = 1'b0;

    // Controls, stray bytes and overlong lead.
    add_row(8'h0D, 1'b0, 1, LF_CH);
    add_row(8'h09, 1'b0, 1, SPACE_CH);
    add_row(8'h7F, 1'b0, 1, QMARK_CH);
    add_row(8'h80, 1'b0, 1, QMARK_CH);
    add_row(8'hC1, 1'b0, 1, QMARK_CH);
    // Two-letter folds and the ellipsis.
    add_row(8'hC3, 1'b0, 0, NO_CHAR);
    add_row(8'h86, 1'b0, FROM_MODEL, NO_CHAR);
    add_row(8'hC3, 1'b0, 0, NO_CHAR);
    add_row(8'h9F, 1'b0, FROM_MODEL, NO_CHAR);
    add_row(8'hE2, 1'b0, 0, NO_CHAR);
    add_row(8'h80, 1'b0, 0, NO_CHAR);
    add_row(8'hA6, 1'b0, FROM_MODEL, NO_CHAR);
    // Code point past the Unicode range, then a surrogate.
    add_row(8'hF4, 1'b0, 0, NO_CHAR);
    add_row(8'h90, 1'b0, 0, NO_CHAR);
    add_row(8'h80, 1'b0, 0, NO_CHAR);
    add_row(8'h80, 1'b0, FROM_MODEL, NO_CHAR);
    add_row(8'hED, 1'b0, 0, NO_CHAR);
    add_row(8'hA0, 1'b0, 0, NO_CHAR);
    add_row(8'h80, 1'b0, FROM_MODEL, NO_CHAR);
    // Broken sequence followed by an embedded NUL.
    add_row(8'hC2, 1'b0, 0, NO_CHAR);
    add_row(8'h00, 1'b0, 1, QMARK_CH);
    // Top lead byte acts as a three-byte lead.
    add_row(8'hFF, 1'b0, 0, NO_CHAR);
    add_row(8'hBF, 1'b0, FROM_MODEL, NO_CHAR);
    add_row(8'hBF, 1'b0, FROM_MODEL, NO_CHAR);
    // Text that ends inside a sequence, then a plain last byte.
    add_row(8'hF0, 1'b1, 1, QMARK_CH);
    add_row(8'h7E, 1'b1, 1, TILDE_CH);

    gen_random_text();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i]);
    wait_for_drain();

    foreach (random_text[i]) begin
      if (i == 20) hold_req = 1'b1;
      if (i == 120) wait_for_drain();
      send_beat(random_text[i]);
    end
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_chars.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
